// ===== hw/rtl/seam_cumulative_energy_top_assert.svh =====
// Assertion macros shared by the seam cumulative energy RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SEAM_CUMULATIVE_ENERGY_TOP_ASSERT_SVH
`define SEAM_CUMULATIVE_ENERGY_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SCE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCE_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define SCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sce_pkg.sv =====
// Shared types and constants for the seam cumulative energy block.
// No dependencies; imported by the top level, the front end and the back end.
package sce_pkg;

    // fixed field widths
    localparam int PIXEL_ENERGY_W = 24;
    localparam int TOTAL_W        = 32;
    localparam int PARENT_W       = 13;
    localparam int SIZE_W         = 13;
    localparam int ROW_W          = 12;
    localparam int MAX_ROWS       = 4096;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int QUEUE_DEPTH    = 2;

    // parent code for "no parent"
    localparam logic [PARENT_W-1:0] NO_PARENT = {PARENT_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLUMNS     = 2'd0,
        REG_NUM_ROWS        = 2'd1,
        REG_MARGIN_ENERGY   = 2'd2,
        REG_INFINITY_ENERGY = 2'd3
    } cfg_reg_t;

    // configuration register file contents
    typedef struct packed {
        logic [SIZE_W-1:0]     num_columns;
        logic [SIZE_W-1:0]     num_rows;
        logic [CFG_DATA_W-1:0] margin_energy;
        logic [CFG_DATA_W-1:0] infinity_energy;
    } cfg_t;

    // per-pixel classification produced by the front end
    typedef struct packed {
        logic first_row;
        logic has_left;
        logic has_right;
        logic last_of_image;
        logic marked;
    } pix_flags_t;

endpackage

// ===== hw/rtl/seam_cumulative_energy_top.sv =====
// Seam carving cumulative energy block: top level with configuration registers.
// Depends on sce_pkg, sce_front, sce_queue and sce_back.
//
// Takes one pixel per clock in row-major order, while the queue is not full, and
// returns one result per pixel in the same order: the cumulative minimum
// vertical-seam energy and the parent column (-1 for none), with m_tlast on the
// last pixel of the image. Sustained rate is one pixel per cycle while m_tready
// stays high. Three registers (queue, line buffer read, output register) lie
// between the s_tdata transaction and m_tvalid. The line buffer read is
// registered and duplicated so the up and up-right parents are read in the same
// cycle, with same-edge writes forwarded.
// The line buffer has no clearing pass and needs no initialization time.
// Configuration writes are accepted every cycle and must only be issued while
// no pixel is in flight.
module seam_cumulative_energy_top
    import sce_pkg::*;
#(
    parameter int MAX_COLUMNS  = 4096,
    parameter int ENERGY_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // [23:0] pixel_energy
    input  logic [0:0]            s_tuser,  // [0] marked
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,  // [31:0] total_energy, [44:32] parent_column
    output logic                  m_tlast   // end_of_image
);

    localparam int ColW   = $clog2(MAX_COLUMNS);
    localparam int QueueW = ColW + PIXEL_ENERGY_W + $bits(pix_flags_t);

    cfg_t cfg_reg;

    logic                      push, q_full, q_valid, q_ready;
    logic [ColW-1:0]           push_col, q_col;
    logic [PIXEL_ENERGY_W-1:0] push_energy, q_energy;
    pix_flags_t                push_flags, q_flags;
    logic [QueueW-1:0]         q_head;
    logic [TOTAL_W-1:0]        total_energy;
    logic [PARENT_W-1:0]       parent_column;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_columns     <= SIZE_W'(4096);
            cfg_reg.num_rows        <= SIZE_W'(4096);
            cfg_reg.margin_energy   <= '0;
            cfg_reg.infinity_energy <= '1;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_COLUMNS:     cfg_reg.num_columns     <= cfg_data[SIZE_W-1:0];
                REG_NUM_ROWS:        cfg_reg.num_rows        <= cfg_data[SIZE_W-1:0];
                REG_MARGIN_ENERGY:   cfg_reg.margin_energy   <= cfg_data;
                REG_INFINITY_ENERGY: cfg_reg.infinity_energy <= cfg_data;
                default: ;
            endcase
        end
    end

    sce_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel_energy (s_tdata[PIXEL_ENERGY_W-1:0]),
        .marked       (s_tuser[0]),
        .q_full       (q_full),
        .push         (push),
        .push_col     (push_col),
        .push_energy  (push_energy),
        .push_flags   (push_flags)
    );

    sce_queue #(
        .WIDTH (QueueW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_col, push_energy, push_flags}),
        .full      (q_full),
        .pop       (q_ready),
        .not_empty (q_valid),
        .head_data (q_head)
    );

    assign {q_col, q_energy, q_flags} = q_head;

    sce_back #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .ENERGY_WIDTH (ENERGY_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_col         (q_col),
        .q_energy      (q_energy),
        .q_flags       (q_flags),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .total_energy  (total_energy),
        .parent_column (parent_column),
        .end_of_image  (m_tlast)
    );

    assign m_tdata = {3'b000, parent_column, total_energy};

endmodule

// ===== hw/rtl/sce_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sce_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sce_queue.sv =====
// Small register FIFO that decouples the front end from the back end.
// Uses the assertion macro header.
`include "seam_cumulative_energy_top_assert.svh"
module sce_queue #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CountW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SCE_ASSERT_NEXT(a_queue_fill, aclk, aresetn, do_push && !do_pop, not_empty, "queue empty after a push")

endmodule

// ===== hw/rtl/sce_front.sv =====
// Front end: accepts pixels, tracks row and column, classifies each pixel.
// Depends on sce_pkg.
module sce_front
    import sce_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIXEL_ENERGY_W-1:0]     pixel_energy,
    input  logic                          marked,
    input  logic                          q_full,
    output logic                          push,
    output logic [$clog2(MAX_COLUMNS)-1:0] push_col,
    output logic [PIXEL_ENERGY_W-1:0]     push_energy,
    output pix_flags_t                    push_flags
);

    localparam int ColW = $clog2(MAX_COLUMNS);

    logic [ColW-1:0]  col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ColW-1:0]  last_col, col;
    logic [ROW_W-1:0] last_row, row;
    logic             at_last_col, at_last_img;

    // effective image size: columns clamped to what the line buffer holds, rows to MAX_ROWS
    always_comb begin
        if (cfg.num_columns == '0) begin
            last_col = '0;
        end else if (32'(cfg.num_columns) > 32'(MAX_COLUMNS)) begin
            last_col = ColW'(MAX_COLUMNS - 1);
        end else begin
            last_col = ColW'(cfg.num_columns - 1'b1);
        end
        if (cfg.num_rows == '0) begin
            last_row = '0;
        end else if (32'(cfg.num_rows) > 32'(MAX_ROWS)) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(cfg.num_rows - 1'b1);
        end
    end

    // position of this pixel, saturated after a size change
    assign col         = (col_reg > last_col) ? last_col : col_reg;
    assign row         = (row_reg > last_row) ? last_row : row_reg;
    assign at_last_col = (col == last_col);
    assign at_last_img = at_last_col && (row == last_row);

    assign s_tready    = !q_full;
    assign push        = s_tvalid && !q_full;
    assign push_col    = col;
    assign push_energy = pixel_energy;

    always_comb begin
        push_flags.first_row     = (row == '0);
        push_flags.has_left      = (col != '0);
        push_flags.has_right     = !at_last_col;
        push_flags.last_of_image = at_last_img;
        push_flags.marked        = marked;
    end

    // raster position advance
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_img ? '0 : row + 1'b1;
            end else begin
                col_next = col + 1'b1;
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== hw/rtl/sce_back.sv =====
// Back end: line buffer read, parent selection, saturating sum, output register.
// Depends on sce_pkg, sce_ram and the assertion macro header.
`include "seam_cumulative_energy_top_assert.svh"
module sce_back
    import sce_pkg::*;
#(
    parameter int MAX_COLUMNS  = 4096,
    parameter int ENERGY_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [$clog2(MAX_COLUMNS)-1:0] q_col,
    input  logic [PIXEL_ENERGY_W-1:0]     q_energy,
    input  pix_flags_t                    q_flags,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TOTAL_W-1:0]            total_energy,
    output logic [PARENT_W-1:0]           parent_column,
    output logic                          end_of_image
);

    localparam int ColW   = $clog2(MAX_COLUMNS);
    localparam int EntryW = ENERGY_WIDTH + 1;
    localparam int SumW   = ((ENERGY_WIDTH > PIXEL_ENERGY_W) ? ENERGY_WIDTH
                                                             : PIXEL_ENERGY_W) + 1;

    // read stage
    logic                      r_valid_reg;
    logic [ColW-1:0]           r_col_reg;
    logic [PIXEL_ENERGY_W-1:0] r_energy_reg;
    pix_flags_t                r_flags_reg;
    logic                      hit_up_reg, hit_ur_reg;
    logic [EntryW-1:0]         fwd_reg;
    logic [EntryW-1:0]         prev_up_reg;

    // output stage
    logic                o_valid_reg;
    logic [TOTAL_W-1:0]  o_total_reg;
    logic [PARENT_W-1:0] o_parent_reg;
    logic                o_last_reg;

    logic                    pop, r_adv;
    logic [ColW:0]           q_col_right;
    logic [EntryW-1:0]       rd_up, rd_ur, up_ent, ur_ent, wr_ent;
    logic [ENERGY_WIDTH-1:0] inf_e, margin_e, best, total;
    logic [SumW-1:0]         sum;
    logic [PARENT_W-1:0]     parent;
    logic                    found;

    assign r_adv       = r_valid_reg && (!o_valid_reg || m_tready);
    assign q_ready     = !r_valid_reg || r_adv;
    assign pop         = q_valid && q_ready;
    assign q_col_right = {1'b0, q_col} + (ColW + 1)'(1);

    // two copies of the previous row, read at the up and up-right columns
    sce_ram #(
        .WIDTH (EntryW),
        .DEPTH (MAX_COLUMNS)
    ) u_ram_up (
        .aclk    (aclk),
        .wr_en   (r_adv),
        .wr_addr (r_col_reg),
        .wr_data (wr_ent),
        .rd_en   (pop),
        .rd_addr (q_col),
        .rd_data (rd_up)
    );

    sce_ram #(
        .WIDTH (EntryW),
        .DEPTH (MAX_COLUMNS)
    ) u_ram_ur (
        .aclk    (aclk),
        .wr_en   (r_adv),
        .wr_addr (r_col_reg),
        .wr_data (wr_ent),
        .rd_en   (pop),
        .rd_addr (ColW'(q_col_right)),
        .rd_data (rd_ur)
    );

    // forward an entry written on the same edge as the read
    assign up_ent = hit_up_reg ? fwd_reg : rd_up;
    assign ur_ent = hit_ur_reg ? fwd_reg : rd_ur;

    assign inf_e    = ENERGY_WIDTH'(cfg.infinity_energy);
    assign margin_e = ENERGY_WIDTH'(cfg.margin_energy);

    // parent search: up, up-right, up-left, strict less-than
    always_comb begin
        best   = inf_e;
        found  = 1'b0;
        parent = NO_PARENT;
        if (!up_ent[ENERGY_WIDTH] && (up_ent[ENERGY_WIDTH-1:0] < best)) begin
            best   = up_ent[ENERGY_WIDTH-1:0];
            parent = PARENT_W'(r_col_reg);
            found  = 1'b1;
        end
        if (r_flags_reg.has_right && !ur_ent[ENERGY_WIDTH] &&
            (ur_ent[ENERGY_WIDTH-1:0] < best)) begin
            best   = ur_ent[ENERGY_WIDTH-1:0];
            parent = PARENT_W'({1'b0, r_col_reg} + (ColW + 1)'(1));
            found  = 1'b1;
        end
        if (r_flags_reg.has_left && !prev_up_reg[ENERGY_WIDTH] &&
            (prev_up_reg[ENERGY_WIDTH-1:0] < best)) begin
            best   = prev_up_reg[ENERGY_WIDTH-1:0];
            parent = PARENT_W'(r_col_reg - ColW'(1));
            found  = 1'b1;
        end
        sum = SumW'(best) + SumW'(r_energy_reg);
        if (r_flags_reg.first_row) begin
            total  = r_flags_reg.marked ? inf_e : margin_e;
            parent = NO_PARENT;
        end else if (r_flags_reg.marked) begin
            total  = inf_e;
            parent = NO_PARENT;
        end else if (!found) begin
            total = inf_e;
        end else if (sum > SumW'(inf_e)) begin
            total = inf_e;
        end else begin
            total = ENERGY_WIDTH'(sum);
        end
    end

    assign wr_ent = {r_flags_reg.marked, total};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                r_valid_reg <= 1'b1;
            end else if (r_adv) begin
                r_valid_reg <= 1'b0;
            end
            if (r_adv) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // read stage payload and forwarding capture
    always_ff @(posedge aclk) begin
        if (pop) begin
            r_col_reg    <= q_col;
            r_energy_reg <= q_energy;
            r_flags_reg  <= q_flags;
            hit_up_reg   <= r_adv && (q_col == r_col_reg);
            hit_ur_reg   <= r_adv && (q_col_right == {1'b0, r_col_reg});
            fwd_reg      <= wr_ent;
        end
        if (r_adv) begin
            prev_up_reg <= up_ent;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (r_adv) begin
            o_total_reg  <= TOTAL_W'(total);
            o_parent_reg <= parent;
            o_last_reg   <= r_flags_reg.last_of_image;
        end
    end

    assign m_tvalid      = o_valid_reg;
    assign total_energy  = o_total_reg;
    assign parent_column = o_parent_reg;
    assign end_of_image  = o_last_reg;

    `SCE_ASSERT_NEXT(a_marked_unreachable, aclk, aresetn, r_adv && r_flags_reg.marked, (o_total_reg == TOTAL_W'($past(inf_e))) && (o_parent_reg == NO_PARENT), "marked pixel not at infinity")
    `SCE_ASSERT_NEXT(a_top_row_orphan, aclk, aresetn, r_adv && r_flags_reg.first_row, o_parent_reg == NO_PARENT, "top row pixel has a parent")
    `SCE_ASSERT_NOW(a_fwd_exclusive, aclk, aresetn, r_valid_reg, !(hit_up_reg && hit_ur_reg), "both parents forwarded")

endmodule

// ===== dv/seam_cumulative_energy_top_tb.sv =====
// Self-checking bench for seam_cumulative_energy_top: row-major pixel streams with random gaps.
// Depends on sce_pkg and the RTL. Each result is checked against an in-bench
// cumulative-energy calculator that keeps its own copy of the line buffer.
module seam_cumulative_energy_top_tb;
    import sce_pkg::*;

    localparam int LINE_DEPTH    = 4096;
    localparam int IDLE_PCT      = 17;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_TRIGGER  = 400;
    localparam int QUIET_START   = 1100;
    localparam int QUIET_END     = 1500;
    localparam int RANDOM_ITEMS  = 900;

    typedef struct packed {
        logic [PIXEL_ENERGY_W-1:0] energy;
        logic                      marked;
    } pixel_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [PARENT_W-1:0] parent;
        logic                eoi;
    } seam_result_t;

    // DUT ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;  // [23:0] pixel_energy
    logic [0:0]            s_tuser   = '0;  // [0] marked
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;         // [31:0] total_energy, [44:32] parent_column
    logic                  m_tlast;         // end_of_image

    // stimulus and scoreboard
    pixel_t       pixel_q[$];
    seam_result_t seam_totals_q[$];
    int           pending_pixels = 0;
    int           pixels_taken   = 0;
    int           results_seen   = 0;
    int           mismatch_count = 0;
    int           cyc            = 0;
    int           stall_cycles   = 0;
    int           hold_left      = 0;
    bit           hold_done      = 1'b0;
    bit           quiet;

    // calculator state: configuration, line buffer, position, parent window
    logic [SIZE_W-1:0]  cal_cols    = 13'd4096;
    logic [SIZE_W-1:0]  cal_rows    = 13'd4096;
    logic [TOTAL_W-1:0] cal_margin  = '0;
    logic [TOTAL_W-1:0] cal_inf     = '1;
    logic [TOTAL_W-1:0] line_energy[LINE_DEPTH];
    logic               line_marked[LINE_DEPTH];
    int unsigned        written_len = 0;  // line buffer columns [0, written_len) hold data
    int unsigned        row_pos     = 0;
    int unsigned        col_pos     = 0;
    logic [TOTAL_W-1:0] win_energy[3] = '{default: '1};
    logic               win_marked[3] = '{default: 1'b1};

    seam_cumulative_energy_top #(
        .MAX_COLUMNS (LINE_DEPTH),
        .ENERGY_WIDTH(TOTAL_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    assign quiet = (cyc >= QUIET_START) && (cyc < QUIET_END);

    // size registers: zero means one, anything past the maximum saturates
    function automatic int unsigned eff_cols(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return v;
    endfunction

    function automatic int unsigned eff_rows(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_ROWS) return MAX_ROWS;
        return v;
    endfunction

    // one pixel through the cumulative-energy recurrence
    task automatic step_seam_energy(input logic [PIXEL_ENERGY_W-1:0] pe, input logic mk);
        int unsigned         ncols, nrows, c, r;
        logic [TOTAL_W-1:0]  best, total;
        logic [PARENT_W-1:0] parent;
        logic                found, last_col, last_img;
        seam_result_t        res;
        ncols = eff_cols(cal_cols);
        nrows = eff_rows(cal_rows);
        c = (col_pos > ncols - 1) ? ncols - 1 : col_pos;
        r = (row_pos > nrows - 1) ? nrows - 1 : row_pos;

        // parent window: up-left carried over, up and up-right from the line buffer
        if (c == 0) begin
            win_energy[0] = cal_inf;
            win_marked[0] = 1'b1;
        end
        win_energy[1] = line_energy[c];
        win_marked[1] = line_marked[c];
        if (c + 1 < ncols) begin
            win_energy[2] = line_energy[c+1];
            win_marked[2] = line_marked[c+1];
        end else begin
            win_energy[2] = cal_inf;
            win_marked[2] = 1'b1;
        end

        parent = NO_PARENT;
        if (r == 0) begin
            total = mk ? cal_inf : cal_margin;
        end else if (mk) begin
            total = cal_inf;
        end else begin
            // up, then up-right, then up-left; ties keep the earlier one
            best  = cal_inf;
            found = 1'b0;
            if (!win_marked[1] && win_energy[1] < best) begin
                best = win_energy[1];
                parent = c[PARENT_W-1:0];
                found = 1'b1;
            end
            if (c + 1 < ncols && !win_marked[2] && win_energy[2] < best) begin
                best = win_energy[2];
                parent = PARENT_W'(c + 1);
                found = 1'b1;
            end
            if (c > 0 && !win_marked[0] && win_energy[0] < best) begin
                best = win_energy[0];
                parent = PARENT_W'(c - 1);
                found = 1'b1;
            end
            if (!found)
                total = cal_inf;
            else if ({8'd0, pe} > cal_inf - best)
                total = cal_inf;
            else
                total = best + {8'd0, pe};
        end

        win_energy[0]  = win_energy[1];
        win_marked[0]  = win_marked[1];
        line_energy[c] = total;
        line_marked[c] = mk;
        if (c + 1 > written_len) written_len = c + 1;

        // advance position
        last_col = (c == ncols - 1);
        last_img = last_col && (r == nrows - 1);
        if (last_col) begin
            col_pos = 0;
            row_pos = last_img ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end

        res.total  = total;
        res.parent = parent;
        res.eoi    = last_img;
        seam_totals_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // pixel driver: presents queued pixels, updates the calculator on each transaction
    always @(posedge aclk) begin : pixel_driver
        pixel_t nxt;
        if (s_tvalid && s_tready) begin
            step_seam_energy(s_tdata, s_tuser[0]);
            pending_pixels--;
            pixels_taken++;
        end
        if (!s_tvalid || s_tready) begin
            if (aresetn && pixel_q.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.energy;
                s_tuser  <= nxt.marked;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off to back the block up
    always @(posedge aclk) begin : result_ready_gen
        if (!hold_done && pixels_taken >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        seam_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (seam_totals_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = seam_totals_q.pop_front();
                if (m_tdata[31:0] !== want.total)
                    report_mismatch("total_energy", m_tdata[31:0], want.total);
                if (m_tdata[44:32] !== want.parent)
                    report_mismatch("parent_column", 32'(m_tdata[44:32]), 32'(want.parent));
                if (m_tlast !== want.eoi)
                    report_mismatch("end_of_image", 32'(m_tlast), 32'(want.eoi));
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin : watchdog
        cyc++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT after %0d idle cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_pixels != 0 || seam_totals_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; caller is at a clock edge, valid stays up between writes
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_NUM_COLUMNS:     cal_cols   = val[SIZE_W-1:0];
            REG_NUM_ROWS:        cal_rows   = val[SIZE_W-1:0];
            REG_MARGIN_ENERGY:   cal_margin = val;
            REG_INFINITY_ENERGY: cal_inf    = val;
            default: ;
        endcase
    endtask

    // drain, then reconfigure; a width growing past the written part of the
    // line buffer in mid-image is pulled back to what has been written
    task automatic run_phase(input logic [31:0] cols_raw, input logic [31:0] rows_raw,
                             input logic [31:0] margin, input logic [31:0] inf_val);
        int unsigned row_eff;
        wait_drained();
        row_eff = row_pos;
        if (row_eff > eff_rows(rows_raw[SIZE_W-1:0]) - 1)
            row_eff = eff_rows(rows_raw[SIZE_W-1:0]) - 1;
        if (row_eff > 0 && eff_cols(cols_raw[SIZE_W-1:0]) > written_len)
            cols_raw = written_len;
        write_reg(REG_NUM_COLUMNS, cols_raw);
        write_reg(REG_NUM_ROWS, rows_raw);
        write_reg(REG_MARGIN_ENERGY, margin);
        write_reg(REG_INFINITY_ENERGY, inf_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic [PIXEL_ENERGY_W-1:0] pe, input logic mk);
        pixel_t p;
        p.energy = pe;
        p.marked = mk;
        pending_pixels++;
        pixel_q.push_back(p);
    endtask

    // energy styles: 0 full range, 1 tiny (ties), 2 extremes, 3 mixed per pixel
    task automatic push_random_pixel(input int mode, input int mark_pct);
        int m;
        logic [PIXEL_ENERGY_W-1:0] pe;
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
            0:       pe = $urandom;
            1:       pe = $urandom_range(0, 3);
            default: pe = $urandom_range(0, 1) ? '1 : '0;
        endcase
        push_pixel(pe, $urandom_range(0, 99) < mark_pct);
    endtask

    // stimulus sequencer
    initial begin : sequencer
        logic [31:0] cols_raw, rows_raw, margin, inf_val;
        int n, mode, mark_pct, r, rand_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: all three parents, tie order, marked pixels, last pixel flag
        run_phase(32'd3, 32'd3, 32'd7, 32'hFFFF_FFFF);
        push_pixel(24'd0, 1'b0);
        push_pixel(24'hFF_FFFF, 1'b1);
        push_pixel(24'd5, 1'b0);
        push_pixel(24'hFF_FFFF, 1'b0);
        push_pixel(24'd1, 1'b0);
        push_pixel(24'd0, 1'b1);
        push_pixel(24'd3, 1'b0);
        push_pixel(24'd2, 1'b0);
        push_pixel(24'd9, 1'b0);

        // zero sizes count as one; margin above infinity is passed through
        run_phase(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd10);
        push_pixel(24'd0, 1'b0);
        push_pixel(24'd1, 1'b1);
        push_pixel(24'hFF_FFFF, 1'b0);

        // saturation at a small infinity, oversized row count
        run_phase(32'd2, 32'd8191, 32'd0, 32'd20);
        push_pixel(24'd0, 1'b0);
        push_pixel(24'd0, 1'b0);
        push_pixel(24'd15, 1'b0);
        push_pixel(24'd4, 1'b0);
        push_pixel(24'd10, 1'b0);
        push_pixel(24'd6, 1'b0);
        push_pixel(24'hFF_FFFF, 1'b0);
        push_pixel(24'd0, 1'b1);
        push_pixel(24'd5, 1'b0);
        push_pixel(24'd5, 1'b0);

        // oversized width: part of a top row, then a wide image that reads it back
        run_phase({19'h7_FFFF, 13'd8191}, 32'd1, $urandom, 32'hFFFF_FFFF);
        repeat (200) push_random_pixel(3, 10);
        run_phase(32'd256, 32'd3, $urandom_range(0, 1000), 32'hFFFF_FFFF);
        repeat (356) push_random_pixel(1, 20);

        // random phases, each ending at an arbitrary point of the image
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5)       cols_raw = 32'd0;
            else if (r < 10) cols_raw = $urandom_range(4096, 8191);
            else if (r < 80) cols_raw = $urandom_range(1, 8);
            else             cols_raw = $urandom_range(9, 40);
            r = $urandom_range(0, 99);
            if (r < 5)       rows_raw = 32'd0;
            else if (r < 10) rows_raw = $urandom_range(4096, 8191);
            else             rows_raw = $urandom_range(1, 6);
            // stray upper bits on the size writes
            if ($urandom_range(0, 1)) begin
                cols_raw[31:SIZE_W] = $urandom;
                rows_raw[31:SIZE_W] = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < 25)      margin = 32'd0;
            else if (r < 40) margin = 32'hFFFF_FFFF;
            else if (r < 70) margin = $urandom_range(0, 1000);
            else             margin = $urandom;
            r = $urandom_range(0, 99);
            if (r < 40)      inf_val = 32'hFFFF_FFFF;
            else if (r < 70) inf_val = $urandom;
            else if (r < 90) inf_val = $urandom_range(0, 32'h0300_0000);
            else if (r < 95) inf_val = 32'd0;
            else             inf_val = $urandom_range(1, 16);
            mode = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       mark_pct = 0;
                1:       mark_pct = 10;
                2:       mark_pct = 30;
                default: mark_pct = 60;
            endcase
            n = $urandom_range(10, 80);
            run_phase(cols_raw, rows_raw, margin, inf_val);
            repeat (n) push_random_pixel(mode, mark_pct);
            rand_items += n;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
